// ===== rtl/scbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// scbrf_pkg
// Types and constants shared by the status and control bit register file.
// ----------------------------------------------------------------------------
package scbrf_pkg;

  localparam int unsigned WordW  = 12;
  localparam int unsigned DesW   = 8;
  localparam int unsigned BitW   = 4;
  localparam int unsigned QuadW  = 3;
  localparam int unsigned WIdxW  = 5;

  // reciprocal of twelve, scaled by 2**11
  localparam int unsigned Recip12    = 171;
  localparam int unsigned Recip12Shr = 11;
  localparam int unsigned BitsPerWord = 12;

  // words with bits refreshed before a read or test
  localparam logic [DesW-1:0] WordMaint = 8'd6;
  localparam logic [DesW-1:0] WordMem   = 8'd14;
  localparam logic [DesW-1:0] WordModel = 8'd15;
  localparam logic [DesW-1:0] WordCpu   = 8'd16;

  localparam logic [QuadW-1:0] MaxQuads = 3'd4;

  // bit positions inside the refreshed words
  localparam int unsigned BitQuad0    = 8;
  localparam int unsigned BitModelOn  = 0;
  localparam int unsigned BitModelOff = 1;
  localparam int unsigned BitCpu2     = 2;
  localparam int unsigned BitStopped  = 0;
  localparam int unsigned BitStopClr  = 1;
  localparam int unsigned BitMonitor  = 3;
  localparam int unsigned BitMonClr   = 4;
  localparam int unsigned BitModelClr = 10;
  localparam int unsigned BitTopClr   = 11;

  // low four bits of word 3 count towards the error test
  localparam logic [WordW-1:0] ErrMask3 = 12'h00F;

  typedef enum logic [2:0] {
    ModeRead    = 3'd0,
    ModeTest    = 3'd1,
    ModeClear   = 3'd2,
    ModeTestClr = 3'd3,
    ModeSet     = 3'd4,
    ModeTestSet = 3'd5,
    ModeClrAll  = 3'd6,
    ModeTestErr = 3'd7
  } mode_e;

  typedef struct packed {
    logic             model_is_865;
    logic [QuadW-1:0] memory_quadrants;
    logic             second_cpu_present;
  } cfg_t;

  typedef struct packed {
    logic cpu0_stopped;
    logic cpu1_stopped;
    logic monitor_active;
  } cpu_status_t;

endpackage

// ===== rtl/scbrf_req_if.sv =====
// ----------------------------------------------------------------------------
// scbrf_req_if
// Request channel: operation, designator and live CPU status flags.
// ----------------------------------------------------------------------------
interface scbrf_req_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic [scbrf_pkg::DesW-1:0] designator;
  logic                      cpu0_stopped;
  logic                      cpu1_stopped;
  logic                      monitor_active;

  modport source (output valid, mode, designator, cpu0_stopped, cpu1_stopped,
                  monitor_active, input ready);
  modport sink   (input valid, mode, designator, cpu0_stopped, cpu1_stopped,
                  monitor_active, output ready);
endinterface

// ===== rtl/scbrf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// scbrf_rsp_if
// Response channel: one read data word per request.
// ----------------------------------------------------------------------------
interface scbrf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scbrf_pkg::WordW-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== rtl/status_control_bit_register_file_core.sv =====
// ----------------------------------------------------------------------------
// status_control_bit_register_file_core
// Status and control bit register file with word and bit operations.
// ----------------------------------------------------------------------------
// One request per clock cycle is taken whenever the sink is ready: the
// request lands in an input register, the addressed status word goes through
// one read-modify-write from there and the result is captured in
// the output register at the same edge that writes the word back. Clear all
// and the error test act on the whole flop file at that edge. The output
// register holds its beat under backpressure while the input register takes
// one more beat and then holds the request channel off, so throughput stays at
// one beat per cycle whenever the sink is ready. The user writes configuration
// through the APB port only while idle; the block does not enforce this.
module status_control_bit_register_file_core #(
  parameter int unsigned NUM_WORDS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  scbrf_req_if.sink          req_i,
  scbrf_rsp_if.source        rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = $clog2(NUM_WORDS);

  typedef enum logic [1:0] {
    RegModel = 2'd0,
    RegQuads = 2'd1,
    RegCpu2  = 2'd2
  } cfg_reg_e;

  // configuration
  scbrf_pkg::cfg_t cfg_q;
  cfg_reg_e        reg_sel;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegModel: cfg_q.model_is_865       <= pwdata[0];
        RegQuads: cfg_q.memory_quadrants   <= pwdata[scbrf_pkg::QuadW-1:0];
        RegCpu2:  cfg_q.second_cpu_present <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegModel: prdata = 32'(cfg_q.model_is_865);
      RegQuads: prdata = 32'(cfg_q.memory_quadrants);
      RegCpu2:  prdata = 32'(cfg_q.second_cpu_present);
      default:  prdata = '0;
    endcase
  end

  // input register
  logic                          in_vld_q;
  scbrf_pkg::mode_e              mode_q;
  logic [scbrf_pkg::DesW-1:0]    des_q;
  scbrf_pkg::cpu_status_t        cpu_q;
  logic                          out_vld_q;
  logic [scbrf_pkg::WordW-1:0]   out_data_q;
  logic                          advance;
  logic                          fire;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;
  assign fire        = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q <= scbrf_pkg::mode_e'(req_i.mode);
      des_q  <= req_i.designator;
      cpu_q  <= '{cpu0_stopped:   req_i.cpu0_stopped,
                  cpu1_stopped:   req_i.cpu1_stopped,
                  monitor_active: req_i.monitor_active};
    end
  end

  // word and bit from the designator: divide by twelve through the reciprocal; a read takes the designator as the word
  logic [2*scbrf_pkg::DesW-1:0]  prod;
  logic [scbrf_pkg::WIdxW-1:0]   bit_word;
  logic [scbrf_pkg::DesW-1:0]    rem_full;
  logic [scbrf_pkg::BitW-1:0]    bit_idx;
  logic [scbrf_pkg::DesW-1:0]    word_idx;
  logic                          in_range;
  logic [IdxW-1:0]               widx;

  assign prod     = (2*scbrf_pkg::DesW)'(des_q) *
                    (2*scbrf_pkg::DesW)'(scbrf_pkg::Recip12);
  assign bit_word = prod[scbrf_pkg::Recip12Shr +: scbrf_pkg::WIdxW];
  assign rem_full = des_q - scbrf_pkg::DesW'(bit_word) *
                    scbrf_pkg::DesW'(scbrf_pkg::BitsPerWord);
  assign bit_idx  = rem_full[scbrf_pkg::BitW-1:0];
  assign word_idx = (mode_q == scbrf_pkg::ModeRead) ? des_q :
                    scbrf_pkg::DesW'(bit_word);
  assign in_range = (word_idx < scbrf_pkg::DesW'(NUM_WORDS));
  assign widx     = word_idx[IdxW-1:0];

  // status word file
  logic [scbrf_pkg::WordW-1:0]   words_q [NUM_WORDS];
  logic [scbrf_pkg::WordW-1:0]   cur_word;
  logic [scbrf_pkg::WordW-1:0]   new_word;
  logic                          bit_res;
  logic                          word_op;
  logic                          err_any;

  assign cur_word = in_range ? words_q[widx] : '0;

  scbrf_alu u_alu (
    .mode_i     (mode_q),
    .word_idx_i (word_idx),
    .bit_idx_i  (bit_idx),
    .word_i     (cur_word),
    .cfg_i      (cfg_q),
    .cpu_i      (cpu_q),
    .word_o     (new_word),
    .result_o   (bit_res)
  );

  assign word_op = (mode_q != scbrf_pkg::ModeClrAll) && (mode_q != scbrf_pkg::ModeTestErr);
  assign err_any = (|words_q[0]) || (|words_q[1]) || (|words_q[2]) ||
                   (|(words_q[3] & scbrf_pkg::ErrMask3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_q[i] <= '0;
      end
    end else if (fire) begin
      if (mode_q == scbrf_pkg::ModeClrAll) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          words_q[i] <= '0;
        end
      end else if (word_op && in_range) begin
        words_q[widx] <= new_word;
      end
    end
  end

  // result register
  logic [scbrf_pkg::WordW-1:0] res_d;

  always_comb begin
    unique case (mode_q)
      scbrf_pkg::ModeRead:    res_d = new_word;
      scbrf_pkg::ModeTestErr: res_d = scbrf_pkg::WordW'(err_any);
      scbrf_pkg::ModeClrAll:  res_d = '0;
      default:                res_d = scbrf_pkg::WordW'(bit_res & in_range);
    endcase
    if (!in_range && (mode_q == scbrf_pkg::ModeRead)) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res_d;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_data_q;

endmodule

// ===== rtl/scbrf_alu.sv =====
// ----------------------------------------------------------------------------
// scbrf_alu
// Refresh of dynamic bits and bit operation on the addressed status word.
// ----------------------------------------------------------------------------
module scbrf_alu (
  input  scbrf_pkg::mode_e                 mode_i,
  input  logic [scbrf_pkg::DesW-1:0]       word_idx_i,
  input  logic [scbrf_pkg::BitW-1:0]       bit_idx_i,
  input  logic [scbrf_pkg::WordW-1:0]      word_i,
  input  scbrf_pkg::cfg_t                  cfg_i,
  input  scbrf_pkg::cpu_status_t           cpu_i,
  output logic [scbrf_pkg::WordW-1:0]      word_o,
  output logic                             result_o
);

  logic                          do_refresh;
  logic [scbrf_pkg::WordW-1:0]   fresh;
  logic [scbrf_pkg::WordW-1:0]   mask;
  logic [scbrf_pkg::QuadW-1:0]   quads;
  logic                          hit;

  assign do_refresh = (mode_i == scbrf_pkg::ModeRead)    ||
                      (mode_i == scbrf_pkg::ModeTest)    ||
                      (mode_i == scbrf_pkg::ModeTestClr) ||
                      (mode_i == scbrf_pkg::ModeTestSet);

  // quadrant counts above the maximum act as none installed
  assign quads = (cfg_i.memory_quadrants <= scbrf_pkg::MaxQuads) ?
                 cfg_i.memory_quadrants : '0;

  always_comb begin
    fresh = word_i;
    if (do_refresh) begin
      if (word_idx_i == scbrf_pkg::WordMaint) begin
        fresh[3:0] = '0;
      end else if (word_idx_i == scbrf_pkg::WordMem) begin
        if (cfg_i.model_is_865) begin
          for (int i = 0; i < 4; i++) begin
            fresh[scbrf_pkg::BitQuad0 + i] = (scbrf_pkg::QuadW'(i) < quads);
          end
        end
      end else if (word_idx_i == scbrf_pkg::WordModel) begin
        if (cfg_i.model_is_865) begin
          fresh[scbrf_pkg::BitModelOn]  = 1'b1;
          fresh[scbrf_pkg::BitModelOff] = 1'b0;
          fresh[scbrf_pkg::BitCpu2]     = cfg_i.second_cpu_present;
        end
      end else if (word_idx_i == scbrf_pkg::WordCpu) begin
        fresh[scbrf_pkg::BitStopped] = cpu_i.cpu0_stopped |
                                       (cfg_i.second_cpu_present & cpu_i.cpu1_stopped);
        fresh[scbrf_pkg::BitStopClr] = 1'b0;
        fresh[scbrf_pkg::BitMonitor] = cpu_i.monitor_active;
        fresh[scbrf_pkg::BitMonClr]  = 1'b0;
        if (cfg_i.model_is_865) begin
          fresh[scbrf_pkg::BitModelClr] = 1'b0;
        end
        fresh[scbrf_pkg::BitTopClr]  = 1'b0;
      end
    end
  end

  assign mask = scbrf_pkg::WordW'(1) << bit_idx_i;
  assign hit  = |(fresh & mask);

  always_comb begin
    word_o   = fresh;
    result_o = 1'b0;
    unique case (mode_i)
      scbrf_pkg::ModeTest:    result_o = hit;
      scbrf_pkg::ModeClear:   word_o   = fresh & ~mask;
      scbrf_pkg::ModeTestClr: begin
        result_o = hit;
        word_o   = fresh & ~mask;
      end
      scbrf_pkg::ModeSet:     word_o   = fresh | mask;
      scbrf_pkg::ModeTestSet: begin
        result_o = hit;
        word_o   = fresh | mask;
      end
      default: begin
        word_o   = fresh;
        result_o = 1'b0;
      end
    endcase
  end

endmodule
